/* rtl/dsd_pkg.sv */
`default_nettype none

package dsd_pkg;

   localparam int MAX_CARDS = 64;
   localparam int ADDR_W    = $clog2(MAX_CARDS);
   localparam int PTR_W     = ADDR_W + 1;
   localparam int CARD_W    = 7;
   localparam int WORD_W    = 15;
   localparam int OP_W      = 2;

   localparam logic [CARD_W-1:0] RESET_DECK_SIZE = CARD_W'(52);
   localparam logic [CARD_W-1:0] MIN_SIZE        = CARD_W'(2);
   localparam logic [CARD_W-1:0] MAX_SIZE        = CARD_W'(MAX_CARDS);
   localparam logic [PTR_W-1:0]  PTR_END         = PTR_W'(MAX_CARDS);
   localparam logic [PTR_W-1:0]  PTR_LAST        = PTR_W'(MAX_CARDS - 1);

   typedef enum logic [OP_W-1:0] {
      OP_RESTART = 2'd0,
      OP_PICK    = 2'd1,
      OP_DEAL    = 2'd2,
      OP_NOP     = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FILL,
      ST_MOD,
      ST_SHIFT,
      ST_DEAL_RD
   } state_type;

   function automatic logic [CARD_W-1:0] clamp_size(input logic [CARD_W-1:0] raw);
      logic [CARD_W-1:0] s;
      s = raw;
      if (raw < MIN_SIZE) begin
         s = MIN_SIZE;
      end else if (raw > MAX_SIZE) begin
         s = MAX_SIZE;
      end
      return s;
   endfunction

   function automatic logic [CARD_W-1:0] calc_left(input logic done,
                                                   input logic [CARD_W-1:0] size,
                                                   input logic [CARD_W-1:0] dealt);
      logic [CARD_W-1:0] l;
      l = '0;
      if (done && (dealt < size)) begin
         l = size - dealt;
      end
      return l;
   endfunction

endpackage

`default_nettype wire

/* rtl/deck_shuffle_dealer_core.sv */
`default_nettype none

// Card shuffler and dealer built around two one-read, one-write card memories.
// A word is taken when start is high while busy is low; req_opcode selects
// restart, pick, deal or no operation, and req_random_word feeds a pick.
// Each word yields exactly one result, shown for one cycle with rsp_valid
// high; the receiver cannot stall, so the result is simply presented.
// A restart sweeps the remaining-card memory in order, writing each entry its index plus one.
// A pick runs a bit-serial modulo by the remaining count, reads the chosen
// card and then shifts the tail of the list down one entry per cycle, up to
// the last memory entry.
// A deal that hands out a card answers after the deck memory read;
// refused picks and deals and no-operation words answer in the next cycle.
// The next word can be taken in the cycle its predecessor's result appears.
// csr_wr_en writes the deck size, which is clamped to 2 through 64 in use.
// Reset returns the deck size to 52 and closes any shuffle; the memories
// keep their contents and are only read after a restart has refilled them.

module deck_shuffle_dealer_core (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output logic                              busy,
   input  wire logic [1:0]                   req_opcode,
   input  wire logic [dsd_pkg::WORD_W-1:0]   req_random_word,
   input  wire logic                         csr_wr_en,
   input  wire logic [dsd_pkg::CARD_W-1:0]   csr_wr_data,
   output logic                              rsp_valid,
   output logic      [dsd_pkg::CARD_W-1:0]   rsp_card_value,
   output logic      [dsd_pkg::CARD_W-1:0]   rsp_cards_left,
   output logic                              rsp_no_card,
   output logic                              rsp_bad_request,
   output logic                              rsp_shuffle_done
);

   dsd_pkg::state_type            state_ff, state_in;
   logic [dsd_pkg::CARD_W-1:0]    deck_size_ff;
   logic [dsd_pkg::CARD_W-1:0]    pick_ff, pick_in;
   logic [dsd_pkg::CARD_W-1:0]    deal_ff, deal_in;
   logic                          open_ff, open_in;
   logic [dsd_pkg::PTR_W-1:0]     ptr_ff, ptr_in;
   logic                          first_ff, first_in;
   logic [dsd_pkg::CARD_W-1:0]    card_ff, card_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [dsd_pkg::CARD_W-1:0]    rsp_card_ff, rsp_card_in;
   logic [dsd_pkg::CARD_W-1:0]    rsp_left_ff, rsp_left_in;
   logic                          rsp_nocard_ff, rsp_nocard_in;
   logic                          rsp_bad_ff, rsp_bad_in;
   logic                          rsp_done_ff, rsp_done_in;

   logic [dsd_pkg::CARD_W-1:0]    size;
   logic                          done_now;
   logic [dsd_pkg::CARD_W-1:0]    pick_next;
   logic [dsd_pkg::CARD_W-1:0]    deal_next;
   logic                          done_after_pick;
   logic [dsd_pkg::PTR_W-1:0]     ptr_back2;

   logic                          rem_we, rem_re;
   logic [dsd_pkg::ADDR_W-1:0]    rem_waddr, rem_raddr;
   logic [dsd_pkg::CARD_W-1:0]    rem_wdata, rem_rdata;
   logic                          deck_we, deck_re;
   logic [dsd_pkg::ADDR_W-1:0]    deck_waddr, deck_raddr;
   logic [dsd_pkg::CARD_W-1:0]    deck_wdata, deck_rdata;

   logic                          mod_start, mod_done;
   logic [dsd_pkg::CARD_W-1:0]    mod_rem;

   dsd_ram #(.ADDR_W(dsd_pkg::ADDR_W), .DATA_W(dsd_pkg::CARD_W)) u_rem_ram (
      .clock   (clock),
      .wr_en   (rem_we),
      .wr_addr (rem_waddr),
      .wr_data (rem_wdata),
      .rd_en   (rem_re),
      .rd_addr (rem_raddr),
      .rd_data (rem_rdata)
   );

   dsd_ram #(.ADDR_W(dsd_pkg::ADDR_W), .DATA_W(dsd_pkg::CARD_W)) u_deck_ram (
      .clock   (clock),
      .wr_en   (deck_we),
      .wr_addr (deck_waddr),
      .wr_data (deck_wdata),
      .rd_en   (deck_re),
      .rd_addr (deck_raddr),
      .rd_data (deck_rdata)
   );

   dsd_mod_unit u_mod (
      .clock     (clock),
      .reset     (reset),
      .mod_start (mod_start),
      .dividend  (req_random_word),
      .divisor   (size - pick_ff),
      .mod_done  (mod_done),
      .remainder (mod_rem)
   );

   assign size            = dsd_pkg::clamp_size(deck_size_ff);
   assign done_now        = open_ff && (pick_ff >= size);
   assign pick_next       = pick_ff + 1'b1;
   assign deal_next       = deal_ff + 1'b1;
   assign done_after_pick = open_ff && (pick_next >= size);
   assign ptr_back2       = ptr_ff - dsd_pkg::PTR_W'(2);

   always_comb begin
      state_in      = state_ff;
      pick_in       = pick_ff;
      deal_in       = deal_ff;
      open_in       = open_ff;
      ptr_in        = ptr_ff;
      first_in      = first_ff;
      card_in       = card_ff;
      rsp_valid_in  = 1'b0;
      rsp_card_in   = rsp_card_ff;
      rsp_left_in   = rsp_left_ff;
      rsp_nocard_in = rsp_nocard_ff;
      rsp_bad_in    = rsp_bad_ff;
      rsp_done_in   = rsp_done_ff;
      rem_we        = 1'b0;
      rem_waddr     = ptr_ff[dsd_pkg::ADDR_W-1:0];
      rem_wdata     = ptr_ff[dsd_pkg::CARD_W-1:0] + 1'b1;
      rem_re        = 1'b0;
      rem_raddr     = ptr_ff[dsd_pkg::ADDR_W-1:0];
      deck_we       = 1'b0;
      deck_waddr    = pick_ff[dsd_pkg::ADDR_W-1:0];
      deck_wdata    = rem_rdata;
      deck_re       = 1'b0;
      deck_raddr    = deal_ff[dsd_pkg::ADDR_W-1:0];
      mod_start     = 1'b0;

      case (state_ff)
         dsd_pkg::ST_IDLE: begin
            if (start) begin
               case (dsd_pkg::opcode_type'(req_opcode))
                  dsd_pkg::OP_RESTART: begin
                     open_in  = 1'b1;
                     pick_in  = '0;
                     deal_in  = '0;
                     ptr_in   = '0;
                     state_in = dsd_pkg::ST_FILL;
                  end
                  dsd_pkg::OP_PICK: begin
                     if (!open_ff || (pick_ff >= size)) begin
                        rsp_valid_in  = 1'b1;
                        rsp_card_in   = '0;
                        rsp_left_in   = dsd_pkg::calc_left(done_now, size, deal_ff);
                        rsp_nocard_in = 1'b0;
                        rsp_bad_in    = 1'b1;
                        rsp_done_in   = done_now;
                     end else begin
                        mod_start = 1'b1;
                        state_in  = dsd_pkg::ST_MOD;
                     end
                  end
                  dsd_pkg::OP_DEAL: begin
                     if (!done_now || (deal_ff >= size)) begin
                        rsp_valid_in  = 1'b1;
                        rsp_card_in   = '0;
                        rsp_left_in   = dsd_pkg::calc_left(done_now, size, deal_ff);
                        rsp_nocard_in = 1'b1;
                        rsp_bad_in    = 1'b0;
                        rsp_done_in   = done_now;
                     end else begin
                        deck_re  = 1'b1;
                        state_in = dsd_pkg::ST_DEAL_RD;
                     end
                  end
                  default: begin
                     rsp_valid_in  = 1'b1;
                     rsp_card_in   = '0;
                     rsp_left_in   = dsd_pkg::calc_left(done_now, size, deal_ff);
                     rsp_nocard_in = 1'b0;
                     rsp_bad_in    = 1'b0;
                     rsp_done_in   = done_now;
                  end
               endcase
            end
         end
         dsd_pkg::ST_FILL: begin
            rem_we = 1'b1;
            ptr_in = ptr_ff + 1'b1;
            if (ptr_ff == dsd_pkg::PTR_LAST) begin
               state_in      = dsd_pkg::ST_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_card_in   = '0;
               rsp_left_in   = dsd_pkg::calc_left(done_now, size, deal_ff);
               rsp_nocard_in = 1'b0;
               rsp_bad_in    = 1'b0;
               rsp_done_in   = done_now;
            end
         end
         dsd_pkg::ST_MOD: begin
            if (mod_done) begin
               rem_re    = 1'b1;
               rem_raddr = mod_rem[dsd_pkg::ADDR_W-1:0];
               ptr_in    = {1'b0, mod_rem[dsd_pkg::ADDR_W-1:0]} + 1'b1;
               first_in  = 1'b1;
               state_in  = dsd_pkg::ST_SHIFT;
            end
         end
         dsd_pkg::ST_SHIFT: begin
            // The read of entry ptr-1 returns now; it moves down to ptr-2.
            first_in = 1'b0;
            if (first_ff) begin
               card_in = rem_rdata;
               deck_we = 1'b1;
            end else begin
               rem_we    = 1'b1;
               rem_waddr = ptr_back2[dsd_pkg::ADDR_W-1:0];
               rem_wdata = rem_rdata;
            end
            if (ptr_ff < dsd_pkg::PTR_END) begin
               rem_re = 1'b1;
               ptr_in = ptr_ff + 1'b1;
            end else begin
               pick_in       = pick_next;
               state_in      = dsd_pkg::ST_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_card_in   = first_ff ? rem_rdata : card_ff;
               rsp_left_in   = dsd_pkg::calc_left(done_after_pick, size, deal_ff);
               rsp_nocard_in = 1'b0;
               rsp_bad_in    = 1'b0;
               rsp_done_in   = done_after_pick;
            end
         end
         dsd_pkg::ST_DEAL_RD: begin
            deal_in       = deal_next;
            state_in      = dsd_pkg::ST_IDLE;
            rsp_valid_in  = 1'b1;
            rsp_card_in   = deck_rdata;
            rsp_left_in   = dsd_pkg::calc_left(done_now, size, deal_next);
            rsp_nocard_in = 1'b0;
            rsp_bad_in    = 1'b0;
            rsp_done_in   = done_now;
         end
         default: begin
            state_in = dsd_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dsd_pkg::ST_IDLE;
         deck_size_ff <= dsd_pkg::RESET_DECK_SIZE;
         pick_ff      <= '0;
         deal_ff      <= '0;
         open_ff      <= 1'b0;
         ptr_ff       <= '0;
         first_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pick_ff      <= pick_in;
         deal_ff      <= deal_in;
         open_ff      <= open_in;
         ptr_ff       <= ptr_in;
         first_ff     <= first_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            deck_size_ff <= csr_wr_data;
         end
      end
      card_ff       <= card_in;
      rsp_card_ff   <= rsp_card_in;
      rsp_left_ff   <= rsp_left_in;
      rsp_nocard_ff <= rsp_nocard_in;
      rsp_bad_ff    <= rsp_bad_in;
      rsp_done_ff   <= rsp_done_in;
   end

   assign busy             = (state_ff != dsd_pkg::ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_card_value   = rsp_card_ff;
   assign rsp_cards_left   = rsp_left_ff;
   assign rsp_no_card      = rsp_nocard_ff;
   assign rsp_bad_request  = rsp_bad_ff;
   assign rsp_shuffle_done = rsp_done_ff;

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_no_card && rsp_bad_request))
      else $error("no_card and bad_request raised together");

   a_refused_no_card: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_no_card || rsp_bad_request)) |-> (rsp_card_value == '0))
      else $error("refused word returned a card");

   a_left_needs_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_shuffle_done) |-> (rsp_cards_left == '0))
      else $error("cards left reported before the shuffle is done");

   a_mod_in_mod_state: assert property (@(posedge clock) disable iff (reset)
      mod_done |-> (state_ff == dsd_pkg::ST_MOD))
      else $error("modulo result arrived outside a pick");

endmodule

`default_nettype wire

/* rtl/dsd_ram.sv */
`default_nettype none

module dsd_ram #(
   parameter int ADDR_W = 6,
   parameter int DATA_W = 7
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [(1 << ADDR_W)];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

/* rtl/dsd_mod_unit.sv */
`default_nettype none

module dsd_mod_unit (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      mod_start,
   input  wire logic [dsd_pkg::WORD_W-1:0] dividend,
   input  wire logic [dsd_pkg::CARD_W-1:0] divisor,
   output logic                           mod_done,
   output logic      [dsd_pkg::CARD_W-1:0] remainder
);

   localparam int CNT_W = $clog2(dsd_pkg::WORD_W);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(dsd_pkg::WORD_W - 1);

   logic                          run_ff, run_in;
   logic                          done_ff, done_in;
   logic [CNT_W-1:0]              cnt_ff, cnt_in;
   logic [dsd_pkg::WORD_W-1:0]    dvd_ff, dvd_in;
   logic [dsd_pkg::CARD_W-1:0]    div_ff, div_in;
   logic [dsd_pkg::CARD_W-1:0]    rem_ff, rem_in;
   logic [dsd_pkg::CARD_W:0]      trial;

   // One quotient bit per cycle; the partial remainder stays below the divisor.
   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      trial   = {rem_ff, dvd_ff[dsd_pkg::WORD_W-1]};
      if (mod_start) begin
         run_in = 1'b1;
         cnt_in = '0;
         dvd_in = dividend;
         div_in = divisor;
         rem_in = '0;
      end else if (run_ff) begin
         dvd_in = {dvd_ff[dsd_pkg::WORD_W-2:0], 1'b0};
         if (trial >= {1'b0, div_ff}) begin
            rem_in = dsd_pkg::CARD_W'(trial - {1'b0, div_ff});
         end else begin
            rem_in = trial[dsd_pkg::CARD_W-1:0];
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_LAST) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
   end

   assign mod_done  = done_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire
